>>> rtl/core/s3fs_pkg.sv
// Shared types, codes and constants of the S3-FIFO/SIEVE replacement unit.
package s3fs_pkg;

	localparam int ID_BITS    = 32;
	localparam int SIZE_BITS  = 24;
	localparam int CACHE_W    = 32;
	localparam int DEF_SLOTS  = 256;

	localparam logic [CACHE_W-1:0] CACHE_RESET = 32'd1048576;

	// cache_bytes / 10 as a multiply by a scaled reciprocal
	localparam logic [32:0] DIV10_MUL   = 33'h0CCCCCCCD;
	localparam int          DIV10_SHIFT = 35;

	localparam logic [1:0] FREQ_MAX = 2'd3;

	typedef enum logic [1:0] {
		CMD_HIT    = 2'd0,
		CMD_MISS   = 2'd1,
		CMD_EVICT  = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERSIZE = 2'd1,
		ST_NONE     = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		Q_FREE  = 2'd0,
		Q_SMALL = 2'd1,
		Q_MAIN  = 2'd2,
		Q_GHOST = 2'd3
	} queue_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [ID_BITS-1:0]   obj_id;
		logic [SIZE_BITS-1:0] obj_bytes;
	} req_t;

	typedef struct packed {
		logic [ID_BITS-1:0] victim_id;
		logic               victim_valid;
		logic               resident;
		status_t            status;
	} rsp_t;

endpackage

>>> rtl/core/s3fs_slot_ram.sv
// Slot table memory: one write port, one read port with registered data.
module s3fs_slot_ram import s3fs_pkg::*; #(
	parameter int DEPTH = DEF_SLOTS,
	parameter int AW    = $clog2(DEF_SLOTS),
	parameter int W     = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [W-1:0]  rd_data
);

	logic [W-1:0] mem [DEPTH];

	// write one record
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// register read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/s3fs_alu.sv
// Shared byte-counter unit: add or subtract, plus an unsigned less-than compare.
module s3fs_alu import s3fs_pkg::*; #(
	parameter int W = 34
) (
	input  alu_op_t      op,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] res,
	output logic         lt
);

	// add or subtract the operands
	always_comb begin
		case (op)
			ALU_ADD: res = a + b;
			ALU_SUB: res = a - b;
			default: res = a;
		endcase
	end

	// compare the operands
	assign lt = (a < b);

endmodule

>>> rtl/core/s3fifo_sieve_replacement_unit.sv
// Hit, miss and remove scan the slot table, stopping early on a match, then relink the lists
// as needed and post the result beat.
// Evict moves objects out of small, steps the SIEVE hand over main and trims ghost entries.
// Requests are taken one beat at a time; input stalls until the sequencer idles.
// Reset: asynchronous, active low; afterwards a clearing pass marks all slots free, and no
// request beat is taken until it ends. Configuration writes are taken always.
module s3fifo_sieve_replacement_unit import s3fs_pkg::*; #(
	parameter int SLOTS = DEF_SLOTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CACHE_W-1:0] cfg_data,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp
);

	localparam int SW   = $clog2(SLOTS);
	localparam int PW   = $clog2(SLOTS + 1);
	localparam int SUMW = SIZE_BITS + SW;
	localparam int CW   = ((SUMW > CACHE_W) ? SUMW : CACHE_W) + 1;
	localparam logic [PW-1:0] NIL = PW'(SLOTS);

	typedef struct packed {
		logic [ID_BITS-1:0]   id;
		logic [SIZE_BITS-1:0] bytes;
		logic [1:0]           freq;
		queue_t               queue;
		logic                 visited;
		logic [PW-1:0]        prev;
		logic [PW-1:0]        next;
	} slot_rec_t;

	localparam int REC_W = $bits(slot_rec_t);

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_SCAN, S_DISP, S_RD, S_RDW, S_FREE, S_ULP, S_ULN, S_PUSH,
		S_FXR, S_FXW, S_WB, S_GREINS, S_NEWFREE, S_NEWINS, S_EVDIV, S_EVSEL,
		S_ES, S_ES2, S_ES3, S_TRIM, S_TRIM2, S_EM, S_EMRD, S_EMCHK, S_DONE
	} state_t;

	state_t state_q, rd_ret_q, fr_ret_q, pu_ret_q, fx_ret_q, wb_ret_q;

	logic [CACHE_W-1:0]   cache_q, target_q;
	cmd_t                 cmd_q;
	logic [ID_BITS-1:0]   id_q, victim_q;
	logic [SIZE_BITS-1:0] size_q;
	logic                 valid_q, resident_q;
	status_t              status_q;
	logic [SW:0]          idx_q;
	logic                 pend_q, free_found_q;
	logic [SW-1:0]        pa_q, free_q, s_q, fx_addr_q;
	slot_rec_t            rec_q;
	logic [PW-1:0]        ul_p_q, ul_n_q, fx_val_q, hand_q;
	logic                 fx_next_q;
	queue_t               pq_q;
	logic [1:0]           ph_q;
	logic [PW-1:0]        head_q [4];
	logic [PW-1:0]        tail_q [4];
	logic [CW-1:0]        cnt_q [4];
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic                 mem_we, mem_rd;
	logic [SW-1:0]        mem_wa, mem_ra;
	logic [REC_W-1:0]     mem_wd, mem_rd_data;
	slot_rec_t            rd_rec, fx_rec;
	logic                 scan_rd, scan_hit;
	alu_op_t              alu_op;
	logic [CW-1:0]        alu_a, alu_b, alu_res;
	logic                 alu_lt;
	logic [CACHE_W+32:0]  div_prod;

	assign rd_rec    = slot_rec_t'(mem_rd_data);
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign div_prod  = cache_q * DIV10_MUL;

	// scan issue and match
	assign scan_rd  = (state_q == S_SCAN) && (idx_q < (SW+1)'(SLOTS));
	assign scan_hit = pend_q && (rd_rec.queue != Q_FREE) && (rd_rec.id == id_q);

	// neighbor link patch
	always_comb begin
		fx_rec = rd_rec;
		if (fx_next_q) begin
			fx_rec.next = fx_val_q;
		end else begin
			fx_rec.prev = fx_val_q;
		end
	end

	// steer the memory ports
	always_comb begin
		mem_rd = 1'b0;
		mem_ra = s_q;
		mem_we = 1'b0;
		mem_wa = s_q;
		mem_wd = REC_W'(rec_q);
		case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				mem_wa = idx_q[SW-1:0];
				mem_wd = '0;
			end
			S_SCAN: begin
				mem_rd = scan_rd;
				mem_ra = idx_q[SW-1:0];
			end
			S_RD: mem_rd = 1'b1;
			S_FXR: begin
				mem_rd = 1'b1;
				mem_ra = fx_addr_q;
			end
			S_FXW: begin
				mem_we = 1'b1;
				mem_wa = fx_addr_q;
				mem_wd = REC_W'(fx_rec);
			end
			S_WB: mem_we = 1'b1;
			default: ;
		endcase
	end

	// steer the shared counter unit
	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			S_DISP: begin
				alu_a = CW'(cache_q);
				alu_b = CW'(size_q);
			end
			S_EVSEL: begin
				alu_a = cnt_q[Q_SMALL];
				alu_b = CW'(target_q);
			end
			S_TRIM: begin
				alu_a = CW'(cache_q);
				alu_b = cnt_q[Q_GHOST];
			end
			S_FREE: begin
				alu_op = ALU_SUB;
				alu_a  = cnt_q[rec_q.queue];
				alu_b  = CW'(rec_q.bytes);
			end
			S_PUSH: begin
				alu_a = cnt_q[pq_q];
				alu_b = CW'(rec_q.bytes);
			end
			default: ;
		endcase
	end

	s3fs_slot_ram #(.DEPTH(SLOTS), .AW(SW), .W(REC_W)) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (mem_wa),
		.wr_data (mem_wd),
		.rd_en   (mem_rd),
		.rd_addr (mem_ra),
		.rd_data (mem_rd_data)
	);

	s3fs_alu #(.W(CW)) u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res),
		.lt  (alu_lt)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_q <= CACHE_RESET;
		end else if (cfg_we) begin
			cache_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			hand_q      <= NIL;
			rsp_valid_q <= 1'b0;
			for (int q = 0; q < 4; q++) begin
				head_q[q] <= NIL;
				tail_q[q] <= NIL;
				cnt_q[q]  <= '0;
			end
		end else begin
			// drop a delivered beat unless the next one is posted now
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == (SW+1)'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						cmd_q        <= req.cmd;
						id_q         <= req.obj_id;
						size_q       <= req.obj_bytes;
						victim_q     <= '0;
						valid_q      <= 1'b0;
						resident_q   <= 1'b0;
						status_q     <= ST_OK;
						idx_q        <= '0;
						pend_q       <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= (req.cmd == CMD_EVICT) ? S_EVDIV : S_SCAN;
					end
				end
				S_SCAN: begin
					pend_q <= scan_rd;
					pa_q   <= idx_q[SW-1:0];
					if (scan_rd) begin
						idx_q <= idx_q + 1'b1;
					end
					if (pend_q && rd_rec.queue == Q_FREE && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q       <= pa_q;
					end
					if (scan_hit) begin
						s_q        <= pa_q;
						rec_q      <= rd_rec;
						resident_q <= (rd_rec.queue != Q_GHOST);
						state_q    <= S_DISP;
					end else if (!scan_rd) begin
						resident_q <= 1'b0;
						rec_q.queue <= Q_FREE;
						state_q    <= S_DISP;
					end
				end
				S_DISP: begin
					if (cmd_q == CMD_REMOVE) begin
						fr_ret_q <= S_WB;
						wb_ret_q <= S_DONE;
						state_q  <= (rec_q.queue != Q_FREE) ? S_FREE : S_DONE;
					end else if (cmd_q == CMD_MISS && alu_lt) begin
						status_q <= ST_OVERSIZE;
						state_q  <= S_DONE;
					end else if (cmd_q == CMD_HIT || resident_q) begin
						if (resident_q) begin
							if (rec_q.queue == Q_MAIN) begin
								rec_q.visited <= 1'b1;
							end else if (rec_q.freq != FREQ_MAX) begin
								rec_q.freq <= rec_q.freq + 2'd1;
							end
							wb_ret_q <= S_DONE;
							state_q  <= S_WB;
						end else begin
							state_q <= S_DONE;
						end
					end else if (rec_q.queue == Q_GHOST) begin
						fr_ret_q <= S_GREINS;
						state_q  <= S_FREE;
					end else if (free_found_q) begin
						s_q     <= free_q;
						state_q <= S_NEWINS;
					end else if (tail_q[Q_GHOST] != NIL) begin
						s_q      <= tail_q[Q_GHOST][SW-1:0];
						rd_ret_q <= S_NEWFREE;
						state_q  <= S_RD;
					end else begin
						status_q <= ST_FULL;
						state_q  <= S_DONE;
					end
				end
				S_GREINS: begin
					rec_q.id    <= id_q;
					rec_q.bytes <= size_q;
					pq_q        <= Q_MAIN;
					pu_ret_q    <= S_WB;
					wb_ret_q    <= S_DONE;
					state_q     <= S_PUSH;
				end
				S_NEWFREE: begin
					fr_ret_q <= S_NEWINS;
					state_q  <= S_FREE;
				end
				S_NEWINS: begin
					rec_q.id    <= id_q;
					rec_q.bytes <= size_q;
					pq_q        <= Q_SMALL;
					pu_ret_q    <= S_WB;
					wb_ret_q    <= S_DONE;
					state_q     <= S_PUSH;
				end
				S_RD: state_q <= S_RDW;
				S_RDW: begin
					rec_q   <= rd_rec;
					state_q <= rd_ret_q;
				end
				S_WB: state_q <= wb_ret_q;
				// take the slot off its queue and its byte count
				S_FREE: begin
					cnt_q[rec_q.queue] <= alu_res;
					if (rec_q.queue == Q_MAIN && hand_q == PW'(s_q)) begin
						if (head_q[Q_MAIN] == tail_q[Q_MAIN]) begin
							hand_q <= NIL;
						end else if (rec_q.prev == NIL) begin
							hand_q <= tail_q[Q_MAIN];
						end else begin
							hand_q <= rec_q.prev;
						end
					end
					if (rec_q.prev == NIL) begin
						head_q[rec_q.queue] <= rec_q.next;
					end
					if (rec_q.next == NIL) begin
						tail_q[rec_q.queue] <= rec_q.prev;
					end
					ul_p_q        <= rec_q.prev;
					ul_n_q        <= rec_q.next;
					rec_q.queue   <= Q_FREE;
					rec_q.visited <= 1'b0;
					state_q       <= S_ULP;
				end
				S_ULP: begin
					if (ul_p_q != NIL) begin
						fx_addr_q <= ul_p_q[SW-1:0];
						fx_next_q <= 1'b1;
						fx_val_q  <= ul_n_q;
						fx_ret_q  <= S_ULN;
						state_q   <= S_FXR;
					end else begin
						state_q <= S_ULN;
					end
				end
				S_ULN: begin
					if (ul_n_q != NIL) begin
						fx_addr_q <= ul_n_q[SW-1:0];
						fx_next_q <= 1'b0;
						fx_val_q  <= ul_p_q;
						fx_ret_q  <= fr_ret_q;
						state_q   <= S_FXR;
					end else begin
						state_q <= fr_ret_q;
					end
				end
				// insert the slot at the head of its new queue
				S_PUSH: begin
					cnt_q[pq_q]   <= alu_res;
					rec_q.queue   <= pq_q;
					rec_q.prev    <= NIL;
					rec_q.next    <= head_q[pq_q];
					rec_q.freq    <= '0;
					rec_q.visited <= 1'b0;
					head_q[pq_q]  <= PW'(s_q);
					if (pq_q == Q_MAIN && head_q[Q_MAIN] == NIL) begin
						hand_q <= PW'(s_q);
					end
					if (head_q[pq_q] != NIL) begin
						fx_addr_q <= head_q[pq_q][SW-1:0];
						fx_next_q <= 1'b0;
						fx_val_q  <= PW'(s_q);
						fx_ret_q  <= pu_ret_q;
						state_q   <= S_FXR;
					end else begin
						tail_q[pq_q] <= PW'(s_q);
						state_q      <= pu_ret_q;
					end
				end
				S_FXR: state_q <= S_FXW;
				S_FXW: state_q <= fx_ret_q;
				S_EVDIV: begin
					target_q <= CACHE_W'(div_prod >> DIV10_SHIFT);
					ph_q     <= 2'd0;
					state_q  <= S_EVSEL;
				end
				// small first when it holds its share, then main, then small again
				S_EVSEL: begin
					case (ph_q)
						2'd0: begin
							if (!alu_lt) begin
								state_q <= S_ES;
							end else begin
								ph_q <= 2'd1;
							end
						end
						2'd1: state_q <= S_EM;
						2'd2: state_q <= S_ES;
						default: begin
							status_q <= ST_NONE;
							state_q  <= S_DONE;
						end
					endcase
				end
				S_ES: begin
					if (tail_q[Q_SMALL] == NIL) begin
						ph_q    <= ph_q + 2'd1;
						state_q <= S_EVSEL;
					end else begin
						s_q      <= tail_q[Q_SMALL][SW-1:0];
						rd_ret_q <= S_ES2;
						state_q  <= S_RD;
					end
				end
				S_ES2: begin
					fr_ret_q <= S_ES3;
					state_q  <= S_FREE;
				end
				S_ES3: begin
					pu_ret_q <= S_WB;
					state_q  <= S_PUSH;
					if (rec_q.freq != 2'd0) begin
						pq_q     <= Q_MAIN;
						wb_ret_q <= S_ES;
					end else begin
						victim_q <= rec_q.id;
						valid_q  <= 1'b1;
						pq_q     <= Q_GHOST;
						wb_ret_q <= S_TRIM;
					end
				end
				// trim the ghost queue down to the capacity
				S_TRIM: begin
					if (alu_lt && tail_q[Q_GHOST] != NIL) begin
						s_q      <= tail_q[Q_GHOST][SW-1:0];
						rd_ret_q <= S_TRIM2;
						state_q  <= S_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_TRIM2: begin
					fr_ret_q <= S_WB;
					wb_ret_q <= S_TRIM;
					state_q  <= S_FREE;
				end
				S_EM: begin
					if (tail_q[Q_MAIN] == NIL) begin
						ph_q    <= ph_q + 2'd1;
						state_q <= S_EVSEL;
					end else begin
						if (hand_q == NIL) begin
							hand_q <= tail_q[Q_MAIN];
						end
						state_q <= S_EMRD;
					end
				end
				S_EMRD: begin
					s_q      <= hand_q[SW-1:0];
					rd_ret_q <= S_EMCHK;
					state_q  <= S_RD;
				end
				// sweep the hand: clear visited and move on, or take the victim
				S_EMCHK: begin
					if (rec_q.visited) begin
						rec_q.visited <= 1'b0;
						hand_q   <= (rec_q.prev == NIL) ? tail_q[Q_MAIN] : rec_q.prev;
						wb_ret_q <= S_EMRD;
						state_q  <= S_WB;
					end else begin
						victim_q <= rec_q.id;
						valid_q  <= 1'b1;
						fr_ret_q <= S_WB;
						wb_ret_q <= S_DONE;
						state_q  <= S_FREE;
					end
				end
				// hand the result beat over once the output register is free
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q        <= 1'b1;
						rsp_q.victim_id    <= victim_q;
						rsp_q.victim_valid <= valid_q;
						rsp_q.resident     <= resident_q;
						rsp_q.status       <= status_q;
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the hand points into main exactly when main holds something
	a_hand_main: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((hand_q == NIL) == (tail_q[Q_MAIN] == NIL)))
		else $error("sieve hand out of step with main queue");

	// small and ghost heads and tails agree on emptiness between requests
	a_list_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
		(((head_q[Q_SMALL] == NIL) == (tail_q[Q_SMALL] == NIL)) &&
		 ((head_q[Q_GHOST] == NIL) == (tail_q[Q_GHOST] == NIL))))
		else $error("queue head and tail disagree");

	// a victim only comes with an ok status
	a_victim_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (!rsp_q.victim_valid || rsp_q.status == ST_OK))
		else $error("victim reported with a failing status");

	// the table scan never writes the slot memory
	a_scan_ro: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !mem_we)
		else $error("slot write during lookup");

endmodule
